FILE: rtl/efts_pkg.sv
// ----------------------------------------------------------------------------
// efts_pkg
// Shared types and constants for the event flag / timer scheduler.
// ----------------------------------------------------------------------------
package efts_pkg;

  localparam int NUM_TASKS_DEF  = 16;
  localparam int NUM_TIMERS_DEF = 8;
  localparam int CLOCK_BITS_DEF = 32;

  typedef enum logic [1:0] {
    KIND_SET    = 2'd0,
    KIND_RUN    = 2'd1,
    KIND_TICK   = 2'd2,
    KIND_CREATE = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    RES_DISPATCH = 2'd0,
    RES_FIRED    = 2'd1,
    RES_CREATE   = 2'd2
  } res_kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [3:0]  task_id;
    logic [7:0]  event_bits;
    logic [31:0] period;
  } in_item_t;

  typedef struct packed {
    res_kind_t  result_kind;
    logic [4:0] task_number;
    logic [7:0] taken_events;
    logic [2:0] timer_slot;
    logic       create_ok;
    logic       last;
  } out_item_t;

  // First result of a run or create item; for a run item, fired timers follow it.
  typedef struct packed {
    res_kind_t  first_kind;
    logic [4:0] task_number;
    logic [7:0] taken;
    logic [2:0] slot;
    logic       ok;
  } batch_t;

endpackage

FILE: rtl/efts_core.sv
// ----------------------------------------------------------------------------
// efts_core
// Scheduler state and update logic: task flags, timer bank, tick clock.
// ----------------------------------------------------------------------------
module efts_core #(
  parameter int NUM_TASKS  = efts_pkg::NUM_TASKS_DEF,
  parameter int NUM_TIMERS = efts_pkg::NUM_TIMERS_DEF,
  parameter int CLOCK_BITS = efts_pkg::CLOCK_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go,
  input  efts_pkg::in_item_t    item,
  output efts_pkg::batch_t      batch,
  output logic [NUM_TIMERS-1:0] fired
);
  import efts_pkg::*;

  logic [7:0]            flags_r   [NUM_TASKS];
  logic [7:0]            flags_nxt [NUM_TASKS];
  logic [NUM_TIMERS-1:0] in_use_r, in_use_nxt;
  logic [CLOCK_BITS-1:0] clock_r, clock_nxt;
  logic [CLOCK_BITS-1:0] checked_r, checked_nxt;
  logic [CLOCK_BITS-1:0] period_r  [NUM_TIMERS];
  logic [CLOCK_BITS-1:0] period_nxt[NUM_TIMERS];
  logic [CLOCK_BITS-1:0] start_r   [NUM_TIMERS];
  logic [CLOCK_BITS-1:0] start_nxt [NUM_TIMERS];

  logic [NUM_TASKS-1:0]  sel;
  logic                  found;
  logic [4:0]            tnum;
  logic [7:0]            taken;
  logic                  free_found;
  logic [2:0]            free_slot;
  logic                  check;
  logic [CLOCK_BITS-1:0] elapsed [NUM_TIMERS];

  always_comb begin
    // lowest-numbered task with pending flags
    found = 1'b0;
    tnum  = '0;
    taken = '0;
    sel   = '0;
    for (int t = 0; t < NUM_TASKS; t++) begin
      if (!found && flags_r[t] != 8'd0) begin
        found  = 1'b1;
        sel[t] = 1'b1;
        tnum   = 5'(t + 1);
        taken  = flags_r[t];
      end
    end

    free_found = 1'b0;
    free_slot  = '0;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (!free_found && !in_use_r[i]) begin
        free_found = 1'b1;
        free_slot  = 3'(i);
      end
    end

    // timers are checked only when the clock moved and task 0 did not run
    check = (clock_r != checked_r) && !sel[0];
    for (int i = 0; i < NUM_TIMERS; i++) begin
      elapsed[i] = clock_r - start_r[i];
      fired[i]   = go && (item.kind == KIND_RUN) && check && in_use_r[i] &&
                   (elapsed[i] >= period_r[i]);
    end

    for (int t = 0; t < NUM_TASKS; t++) flags_nxt[t] = flags_r[t];
    for (int i = 0; i < NUM_TIMERS; i++) begin
      period_nxt[i] = period_r[i];
      start_nxt[i]  = fired[i] ? start_r[i] + period_r[i] : start_r[i];
    end
    in_use_nxt  = in_use_r;
    clock_nxt   = clock_r;
    checked_nxt = checked_r;
    batch       = '0;

    case (item.kind)
      KIND_SET: begin
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (go && 32'(item.task_id) == t) flags_nxt[t] = flags_r[t] | item.event_bits;
        end
      end
      KIND_TICK: begin
        if (go) clock_nxt = clock_r + 1'b1;
      end
      KIND_CREATE: begin
        batch.first_kind = RES_CREATE;
        batch.ok         = free_found;
        batch.slot       = free_slot;
        for (int i = 0; i < NUM_TIMERS; i++) begin
          if (go && free_found && free_slot == 3'(i)) begin
            period_nxt[i] = CLOCK_BITS'(item.period);
            start_nxt[i]  = clock_r;
            in_use_nxt[i] = 1'b1;
          end
        end
      end
      KIND_RUN: begin
        batch.first_kind  = RES_DISPATCH;
        batch.task_number = tnum;
        batch.taken       = taken;
        for (int t = 0; t < NUM_TASKS; t++) begin
          if (go && sel[t]) flags_nxt[t] = 8'd0;
        end
        if (go && check) checked_nxt = clock_r;
      end
      default: begin
        batch = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int t = 0; t < NUM_TASKS; t++) flags_r[t] <= '0;
      in_use_r  <= '0;
      clock_r   <= '0;
      checked_r <= '0;
    end else begin
      for (int t = 0; t < NUM_TASKS; t++) flags_r[t] <= flags_nxt[t];
      in_use_r  <= in_use_nxt;
      clock_r   <= clock_nxt;
      checked_r <= checked_nxt;
    end
  end

  // timer period/start are only read for live timers
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_TIMERS; i++) begin
      period_r[i] <= period_nxt[i];
      start_r[i]  <= start_nxt[i];
    end
  end

endmodule

FILE: rtl/efts_out.sv
// ----------------------------------------------------------------------------
// efts_out
// Result register: sends the first result of an item, then one result per
// fired timer in ascending slot order.
// ----------------------------------------------------------------------------
module efts_out #(
  parameter int NUM_TIMERS = efts_pkg::NUM_TIMERS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  efts_pkg::batch_t      batch,
  input  logic [NUM_TIMERS-1:0] fired,
  output logic                  ready,
  output logic                  out_valid,
  input  logic                  out_stall,
  output efts_pkg::out_item_t   out_data
);
  import efts_pkg::*;

  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_r, out_nxt;
  logic [NUM_TIMERS-1:0] pend_r, pend_nxt;
  logic [NUM_TIMERS-1:0] pend_left;
  logic [2:0]            next_slot;
  logic                  bit_found;
  logic                  xfer;

  assign xfer      = out_valid_r && !out_stall;
  assign ready     = !out_valid_r || (xfer && pend_r == '0);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    bit_found = 1'b0;
    next_slot = '0;
    pend_left = pend_r;
    for (int i = 0; i < NUM_TIMERS; i++) begin
      if (!bit_found && pend_r[i]) begin
        bit_found    = 1'b1;
        next_slot    = 3'(i);
        pend_left[i] = 1'b0;
      end
    end

    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    if (load) begin
      out_valid_nxt        = 1'b1;
      out_nxt.result_kind  = batch.first_kind;
      out_nxt.task_number  = batch.task_number;
      out_nxt.taken_events = batch.taken;
      out_nxt.timer_slot   = batch.slot;
      out_nxt.create_ok    = batch.ok;
      out_nxt.last         = (fired == '0);
      pend_nxt             = fired;
    end else if (xfer) begin
      if (bit_found) begin
        out_nxt.result_kind  = RES_FIRED;
        out_nxt.task_number  = '0;
        out_nxt.taken_events = '0;
        out_nxt.timer_slot   = next_slot;
        out_nxt.create_ok    = 1'b0;
        out_nxt.last         = (pend_left == '0);
        pend_nxt             = pend_left;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

endmodule

FILE: rtl/event_flag_task_and_timer_scheduler_unit.sv
// ----------------------------------------------------------------------------
// event_flag_task_and_timer_scheduler_unit
// Event flag scheduler with periodic timers: input register, state update,
// result register.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+--------------------
//   in_      | in        | in_valid / in_stall  | in_data  (in_item_t)
//   out_     | out       | out_valid / out_stall| out_data (out_item_t)
//
// Set-event and tick items take one cycle and may pass while results drain.
// A run or create item is processed once the result register is free; a run
// item then yields 1 + (fired timers) results and a create item one result,
// one per cycle of output transfer.
// Reset clears all flags, the clock and the timer bank; no clearing pass.
// A stalled output holds its result; the input stalls while a result-bearing
// item waits for the result register.
// ----------------------------------------------------------------------------
module event_flag_task_and_timer_scheduler_unit #(
  parameter int NUM_TASKS  = efts_pkg::NUM_TASKS_DEF,
  parameter int NUM_TIMERS = efts_pkg::NUM_TIMERS_DEF,
  parameter int CLOCK_BITS = efts_pkg::CLOCK_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  efts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output efts_pkg::out_item_t out_data
);
  import efts_pkg::*;

  logic                  in_valid_r, in_valid_nxt;
  in_item_t              in_r;
  logic                  has_result;
  logic                  ser_ready;
  logic                  go;
  batch_t                batch;
  logic [NUM_TIMERS-1:0] fired;

  assign has_result = (in_r.kind == KIND_RUN) || (in_r.kind == KIND_CREATE);
  assign go         = in_valid_r && (!has_result || ser_ready);
  assign in_stall   = in_valid_r && !go;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && !in_stall) begin
      in_valid_nxt = 1'b1;
    end else if (go) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) in_r <= in_data;
  end

  efts_core #(
    .NUM_TASKS  (NUM_TASKS),
    .NUM_TIMERS (NUM_TIMERS),
    .CLOCK_BITS (CLOCK_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (go),
    .item  (in_r),
    .batch (batch),
    .fired (fired)
  );

  efts_out #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (go && has_result),
    .batch     (batch),
    .fired     (fired),
    .ready     (ser_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

FILE: verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the event flag / timer scheduler. A queue of
// directed and random items feeds a bursty driver; a scoreboard model
// predicts every dispatch, timer-fired and create answer, and the monitor
// checks each output transfer in order against it.
// ----------------------------------------------------------------------------
module testbench;
  import efts_pkg::*;

  localparam int NUM_TASKS_P  = NUM_TASKS_DEF;
  localparam int NUM_TIMERS_P = NUM_TIMERS_DEF;
  localparam int CLK_W        = CLOCK_BITS_DEF;
  localparam int RANDOM_ITEMS = 400;
  localparam int RESET_CYCLES = 12;
  localparam int HOLD_START   = 300;
  localparam int HOLD_LEN     = 250;
  localparam int QUIET_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 20;
  localparam logic [4:0] TASK0_NUMBER = 5'd1;

  typedef enum int {RX_FLOW, RX_LIGHT, RX_HEAVY} rx_mode_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  event_flag_task_and_timer_scheduler_unit DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #5 clk = ~clk;

  // Scheduler state as seen by the scoreboard
  logic [7:0]              flag_bank [NUM_TASKS_P];
  logic [NUM_TIMERS_P-1:0] live_timers = '0;
  logic [CLK_W-1:0]        interval_bank [NUM_TIMERS_P];
  logic [CLK_W-1:0]        origin_bank [NUM_TIMERS_P];
  logic [CLK_W-1:0]        ticks_now = '0;
  logic [CLK_W-1:0]        ticks_seen = '0;

  in_item_t  pending_items[$];
  out_item_t awaited_results[$];

  int  items_taken = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  quiet_cycles = 0;
  int  rx_cycles = 0;
  int  hold_left = 0;
  int  mode_left = 0;
  rx_mode_t rx_mode = RX_FLOW;
  bit  wind_down = 1'b0;
  bit  failed = 1'b0;
  out_item_t got_result;
  out_item_t want_result;

  initial begin
    foreach (flag_bank[t]) flag_bank[t] = '0;
    foreach (interval_bank[t]) interval_bank[t] = '0;
    foreach (origin_bank[t]) origin_bank[t] = '0;
  end

  task automatic predict_item(input in_item_t it);
    out_item_t batch[$];
    out_item_t res;
    int slot;
    logic [CLK_W-1:0] elapsed;
    case (it.kind)
      KIND_SET: begin
        if (int'(it.task_id) < NUM_TASKS_P)
          flag_bank[it.task_id] = flag_bank[it.task_id] | it.event_bits;
      end
      KIND_TICK: ticks_now = ticks_now + 1'b1;
      KIND_CREATE: begin
        res = '0;
        res.result_kind = RES_CREATE;
        res.last = 1'b1;
        slot = -1;
        for (int t = 0; t < NUM_TIMERS_P; t++)
          if (!live_timers[t] && slot < 0) slot = t;
        if (slot >= 0) begin
          interval_bank[slot] = CLK_W'(it.period);
          origin_bank[slot] = ticks_now;
          live_timers[slot] = 1'b1;
          res.timer_slot = 3'(slot);
          res.create_ok = 1'b1;
        end
        awaited_results.push_back(res);
      end
      default: begin
        res = '0;
        res.result_kind = RES_DISPATCH;
        for (int t = 0; t < NUM_TASKS_P; t++) begin
          if (flag_bank[t] != 8'h00 && res.task_number == 5'd0) begin
            res.task_number = 5'(t + 1);
            res.taken_events = flag_bank[t];
            flag_bank[t] = 8'h00;
          end
        end
        batch.push_back(res);
        // timers are skipped when task 0 ran or the clock has not moved
        if (ticks_now != ticks_seen && res.task_number != TASK0_NUMBER) begin
          ticks_seen = ticks_now;
          for (int t = 0; t < NUM_TIMERS_P; t++) begin
            if (live_timers[t]) begin
              elapsed = ticks_now - origin_bank[t];
              if (elapsed >= interval_bank[t]) begin
                origin_bank[t] = origin_bank[t] + interval_bank[t];
                res = '0;
                res.result_kind = RES_FIRED;
                res.timer_slot = 3'(t);
                batch.push_back(res);
              end
            end
          end
        end
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[k]) awaited_results.push_back(batch[k]);
      end
    endcase
  endtask

  function automatic in_item_t make_item(kind_t k, logic [3:0] id, logic [7:0] bits,
                                         logic [31:0] per);
    in_item_t it;
    it.kind = k;
    it.task_id = id;
    it.event_bits = bits;
    it.period = per;
    return it;
  endfunction

  function automatic bit field_bad(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // Driver: bursts of transfers with random gaps, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_item(in_data);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_valid <= 1'b1;
          in_data <= pending_items.pop_front();
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: own stall pattern plus one long hold-off to back up the block
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      rx_cycles++;
      if (rx_cycles == HOLD_START) hold_left = HOLD_LEN;
      if (wind_down) begin
        out_stall <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        if (mode_left == 0) begin
          rx_mode = rx_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 80);
        end else begin
          mode_left--;
        end
        case (rx_mode)
          RX_FLOW:  out_stall <= 1'b0;
          RX_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:  out_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      got_result = out_data;
      if (awaited_results.size() == 0) begin
        $error("result with nothing pending: kind %0d task %0d slot %0d",
               got_result.result_kind, got_result.task_number, got_result.timer_slot);
        failed = 1'b1;
      end else begin
        want_result = awaited_results.pop_front();
        if (field_bad("result_kind", want_result.result_kind, got_result.result_kind) |
            field_bad("task_number", want_result.task_number, got_result.task_number) |
            field_bad("taken_events", want_result.taken_events, got_result.taken_events) |
            field_bad("timer_slot", want_result.timer_slot, got_result.timer_slot) |
            field_bad("create_ok", want_result.create_ok, got_result.create_ok) |
            field_bad("last", want_result.last, got_result.last))
          failed = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("status: fail");
          $finish;
        end
      end
    end
  end

  initial begin
    int total;
    int pick;
    int n;
    in_item_t it;

    // directed: empty run, task 0 priority, zero/huge periods, bank full
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd2));
    pending_items.push_back(make_item(KIND_SET, 4'd15, 8'hFF, 32'd0));
    pending_items.push_back(make_item(KIND_SET, 4'd0, 8'h01, 32'd0));
    pending_items.push_back(make_item(KIND_SET, 4'd0, 8'h80, 32'd0));
    pending_items.push_back(make_item(KIND_TICK, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_TICK, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_TICK, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_SET, 4'd3, 8'hAA, 32'd0));
    pending_items.push_back(make_item(KIND_SET, 4'd7, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd1));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd64));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd3));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd4));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd5));
    pending_items.push_back(make_item(KIND_CREATE, 4'd0, 8'h00, 32'd7));
    pending_items.push_back(make_item(KIND_CREATE, 4'hF, 8'hFF, 32'hFFFF_FFFF));
    pending_items.push_back(make_item(KIND_TICK, 4'd0, 8'h00, 32'd0));
    pending_items.push_back(make_item(KIND_RUN, 4'd0, 8'h00, 32'd0));

    // random: unused fields stay random; tick runs let many timers fire at once
    n = 0;
    while (n < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      it.task_id = ($urandom_range(0, 1) == 0) ? 4'($urandom_range(0, 3))
                                                : 4'($urandom_range(0, 15));
      it.event_bits = ($urandom_range(0, 3) == 0) ? 8'(8'h01 << $urandom_range(0, 7))
                                                  : 8'($urandom);
      it.period = $urandom;
      if (pick < 5) begin
        it.kind = KIND_TICK;
        repeat ($urandom_range(8, 20)) begin
          it.period = $urandom;
          pending_items.push_back(it);
          n++;
        end
      end else begin
        if (pick < 38) it.kind = KIND_SET;
        else if (pick < 70) it.kind = KIND_RUN;
        else if (pick < 92) it.kind = KIND_TICK;
        else it.kind = KIND_CREATE;
        pending_items.push_back(it);
        n++;
      end
    end
    total = pending_items.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    while (items_taken < total) @(negedge clk);
    while (awaited_results.size() > 0) @(negedge clk);
    wind_down = 1'b1;
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (!failed && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
